// File: rtl/core/dscfd_pkg.sv
// Shared constants for the DLE-stuffed CAN frame decoder.
package dscfd_pkg;

	localparam int MAX_PAYLOAD_BYTES = 8;

	localparam int BYTE_W    = 8;
	localparam int IDX_W     = 4;
	localparam int ID_W      = 32;
	localparam int LEN_W     = 4;
	localparam int PAYLOAD_W = 64;
	localparam int OUT_W     = ID_W + LEN_W + PAYLOAD_W;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_END    = 2'd2;

	localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'h10;
	localparam logic [BYTE_W-1:0] START_RESET  = 8'h02;
	localparam logic [BYTE_W-1:0] END_RESET    = 8'h03;

	// decoded byte positions
	localparam int ID_FIRST_IDX  = 1;
	localparam int LEN_IDX       = 6;
	localparam int PAY_FIRST_IDX = 7;
	localparam logic [IDX_W-1:0] IDX_MAX = 4'd15;

endpackage

// File: rtl/core/dle_stuffed_can_frame_decoder.sv
// Top level: DLE/STX/ETX deframer with XOR check, emitting decoded CAN frames.

// Accepts one raw byte per clock on the s_ stream and delivers one request on
// the m_ stream for each valid frame (unescaped escape/start ... escape/end,
// at least one byte, XOR of all unstuffed bytes zero). Each byte is held in the
// input register while the frame state is updated in a single pass, and the
// result of a closing byte is registered in the output register. The output
// register frees the input side: input stalls only when a new result is due
// while the previous one is still waiting to be taken. The user must write
// configuration (escape, start, end codes) while the block is idle; not enforced.
module dle_stuffed_can_frame_decoder
	import dscfd_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,

	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [BYTE_W-1:0]       cfg_data,

	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [BYTE_W-1:0]       s_tdata,   // [7:0] rx_byte

	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [OUT_TDATA_W-1:0]  m_tdata    // [31:0] frame_id, [35:32] data_length,
	                                           // [99:36] payload, rest zero
);

	logic [BYTE_W-1:0] escape_q, start_q, end_q;

	logic              valid_s1;
	logic [BYTE_W-1:0] rx_byte_s1;

	logic                 in_frame_q, esc_seen_q;
	logic [IDX_W-1:0]     idx_q;
	logic [BYTE_W-1:0]    xor_q;
	logic [ID_W-1:0]      id_q;
	logic [BYTE_W-1:0]    len_q;
	logic [PAYLOAD_W-1:0] pay_q;

	logic                 in_frame_d, esc_seen_d;
	logic [IDX_W-1:0]     idx_d;
	logic [BYTE_W-1:0]    xor_d;
	logic [ID_W-1:0]      id_d;
	logic [BYTE_W-1:0]    len_d;
	logic [PAYLOAD_W-1:0] pay_d;

	logic open_frame, take, close, result, advance;
	logic [LEN_W-1:0]     len_clamp;
	logic [PAYLOAD_W-1:0] pay_masked;

	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_q <= ESCAPE_RESET;
			start_q  <= START_RESET;
			end_q    <= END_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ESCAPE: escape_q <= cfg_data;
				REG_START:  start_q  <= cfg_data;
				REG_END:    end_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		open_frame = 1'b0;
		take       = 1'b0;
		close      = 1'b0;
		in_frame_d = in_frame_q;
		esc_seen_d = esc_seen_q;
		if (!in_frame_q) begin
			if (esc_seen_q) begin
				if (rx_byte_s1 == start_q)
					open_frame = 1'b1;
				else
					esc_seen_d = 1'b0;
			end else if (rx_byte_s1 == escape_q) begin
				esc_seen_d = 1'b1;
			end
		end else if (!esc_seen_q) begin
			if (rx_byte_s1 == escape_q)
				esc_seen_d = 1'b1;
			else
				take = 1'b1;
		end else begin
			esc_seen_d = 1'b0;
			if (rx_byte_s1 == start_q) begin
				open_frame = 1'b1;
			end else if (rx_byte_s1 == end_q) begin
				in_frame_d = 1'b0;
				close      = 1'b1;
			end else if (rx_byte_s1 == escape_q) begin
				take = 1'b1;
			end else begin
				in_frame_d = 1'b0;
			end
		end

		idx_d = idx_q;
		xor_d = xor_q;
		id_d  = id_q;
		len_d = len_q;
		pay_d = pay_q;
		if (open_frame) begin
			in_frame_d = 1'b1;
			esc_seen_d = 1'b0;
			idx_d = '0;
			xor_d = '0;
			id_d  = '0;
			len_d = '0;
			pay_d = '0;
		end
		if (take) begin
			xor_d = xor_q ^ rx_byte_s1;
			for (int k = 0; k < ID_W / BYTE_W; k++) begin
				if (idx_q == IDX_W'(ID_FIRST_IDX + k))
					id_d[BYTE_W*k +: BYTE_W] = rx_byte_s1;
			end
			if (idx_q == IDX_W'(LEN_IDX))
				len_d = rx_byte_s1;
			for (int k = 0; k < MAX_PAYLOAD_BYTES; k++) begin
				if (idx_q == IDX_W'(PAY_FIRST_IDX + k))
					pay_d[BYTE_W*k +: BYTE_W] = rx_byte_s1;
			end
			if (idx_q != IDX_MAX)
				idx_d = idx_q + 1'b1;
		end

		result = close && (idx_q != '0) && (xor_q == '0);

		if (len_q > BYTE_W'(MAX_PAYLOAD_BYTES))
			len_clamp = LEN_W'(MAX_PAYLOAD_BYTES);
		else
			len_clamp = len_q[LEN_W-1:0];

		for (int k = 0; k < PAYLOAD_W / BYTE_W; k++) begin
			if (LEN_W'(k) < len_clamp)
				pay_masked[BYTE_W*k +: BYTE_W] = pay_q[BYTE_W*k +: BYTE_W];
			else
				pay_masked[BYTE_W*k +: BYTE_W] = '0;
		end
	end

	// a byte that yields a result waits while the output register is full and m_tready is low
	assign advance  = valid_s1 && (!result || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			rx_byte_s1 <= s_tdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			esc_seen_q <= 1'b0;
			idx_q      <= '0;
			xor_q      <= '0;
		end else if (advance) begin
			in_frame_q <= in_frame_d;
			esc_seen_q <= esc_seen_d;
			idx_q      <= idx_d;
			xor_q      <= xor_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			id_q  <= id_d;
			len_q <= len_d;
			pay_q <= pay_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && result) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result)
			out_data_q <= OUT_TDATA_W'({pay_masked, len_clamp, id_q});
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule
